>>> rtl/bth_pkg.sv
// Package for the boundary tag heap allocator: types, codes and constants.
// No dependencies; used by bth_front, bth_back, the core and the testbench.
package bth_pkg;

    localparam int unsigned HEAP_BYTES_DEF = 32768;
    localparam int unsigned TAG_W = 17;
    localparam int unsigned SIZE_W = 16;
    localparam int unsigned OFF_W = 17;

    typedef enum logic [1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_FORMAT = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_SMALL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_FORMAT = 2'd2,
        OP_RESULT = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [OFF_W-1:0]    arg;
        status_t             status;
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FMT0,
        S_FMT1,
        S_A_RD,
        S_A_WT,
        S_A_CHK,
        S_A_W0,
        S_A_W1,
        S_A_W2,
        S_A_W3,
        S_F_RD,
        S_F_WT,
        S_F_CHK,
        S_F_NRD,
        S_F_NWT,
        S_F_PRD,
        S_F_PWT,
        S_F_W0,
        S_F_W1,
        S_OUT
    } state_t;

endpackage

>>> rtl/bth_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bth_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/bth_front.sv
// Front end: accepts input transfers, classifies them and queues commands.
// Depends on bth_pkg.
module bth_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [32:0]             s_tdata,
    output logic                    q_valid,
    input  logic                    q_pop,
    output bth_pkg::cmd_t           q_cmd
);

    localparam int unsigned QD = 2;

    bth_pkg::cmd_t   q_reg [QD];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    bth_pkg::cmd_t   cls;
    logic [1:0]      kind;
    logic [15:0]     req;
    logic [14:0]     baddr;
    logic            push;

    assign kind  = s_tdata[1:0];
    assign req   = s_tdata[17:2];
    assign baddr = s_tdata[32:18];

    always_comb
    begin
        cls.op     = bth_pkg::OP_RESULT;
        cls.arg    = '0;
        cls.status = bth_pkg::ST_DONE;
        unique case (bth_pkg::kind_t'(kind))
            bth_pkg::KIND_ALLOC:
            begin
                if (req == 16'd0)
                begin
                    cls.status = bth_pkg::ST_NOFIT;
                end
                else
                begin
                    cls.op  = bth_pkg::OP_ALLOC;
                    cls.arg = ({1'b0, req} + 17'd7) & ~17'd7;
                end
            end
            bth_pkg::KIND_FREE:
            begin
                if (baddr != 15'd0 && baddr[2:0] == 3'd0)
                begin
                    cls.op  = bth_pkg::OP_FREE;
                    cls.arg = {2'b00, baddr} - 17'd8;
                end
            end
            bth_pkg::KIND_FORMAT: cls.op = bth_pkg::OP_FORMAT;
            bth_pkg::KIND_NONE:   cls.op = bth_pkg::OP_RESULT;
        endcase
    end

    assign s_tready = (cnt_reg != 2'(QD));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

endmodule

>>> rtl/bth_back.sv
// Back end: walks and rewrites the boundary tags in the tag RAM.
// Depends on bth_pkg and bth_ram.
module bth_back #(
    parameter int unsigned HEAP_BYTES = bth_pkg::HEAP_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  bth_pkg::cmd_t         q_cmd,
    input  logic [15:0]           heap_bytes,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [14:0]           m_addr,
    output logic [1:0]            m_status
);

    localparam int unsigned DEPTH = HEAP_BYTES / 8;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned OW = bth_pkg::OFF_W + 4;
    localparam logic [OW-1:0] CAP = OW'(HEAP_BYTES & ~7);

    bth_pkg::state_t state_reg, state_next;
    logic [OW-1:0] limit_reg, limit_next;
    logic [OW-1:0] at_reg, at_next;
    logic [OW-1:0] need_reg, need_next;
    logic [OW-1:0] size_reg, size_next;
    logic [OW-1:0] hdr_reg, hdr_next;
    logic [14:0]   oaddr_reg, oaddr_next;
    logic [1:0]    ost_reg, ost_next;
    logic          ov_reg, ov_next;

    logic          we;
    logic [OW-1:0] woff, wsize;
    logic          wused;
    logic [OW-1:0] roff;
    logic [bth_pkg::TAG_W-1:0] rdata;
    logic [AW-1:0] raddr;
    logic          wr_ok;
    logic [OW-1:0] tsz, endv;
    logic          tused, szok;

    assign tsz   = OW'(rdata[15:0]);
    assign tused = rdata[16];
    assign endv  = OW'(heap_bytes & 16'hFFF8) > CAP ? CAP : OW'(heap_bytes & 16'hFFF8);

    function automatic logic size_ok(input logic [OW-1:0] off, input logic [OW-1:0] sz,
                                     input logic [OW-1:0] lim);
        size_ok = sz >= OW'(16) && sz[2:0] == 3'd0 && sz <= lim && off <= lim - sz;
    endfunction

    assign szok  = size_ok(at_reg, tsz, limit_reg);
    assign wr_ok = (woff >> 3) < OW'(DEPTH);
    assign raddr = we ? AW'(woff >> 3) : AW'(roff >> 3);

    bth_ram #(.WIDTH(bth_pkg::TAG_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we && wr_ok),
        .addr  (raddr),
        .wdata ({wused, wsize[15:0]}),
        .rdata (rdata)
    );

    assign m_tvalid = ov_reg;
    assign m_addr   = oaddr_reg;
    assign m_status = ost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bth_pkg::S_IDLE;
            limit_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            limit_reg <= limit_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg    <= at_next;
        need_reg  <= need_next;
        size_reg  <= size_next;
        hdr_reg   <= hdr_next;
        oaddr_reg <= oaddr_next;
        ost_reg   <= ost_next;
    end

    always_comb
    begin
        state_next = state_reg;
        limit_next = limit_reg;
        at_next    = at_reg;
        need_next  = need_reg;
        size_next  = size_reg;
        hdr_next   = hdr_reg;
        oaddr_next = oaddr_reg;
        ost_next   = ost_reg;
        ov_next    = ov_reg && !m_tready;
        q_pop      = 1'b0;
        we         = 1'b0;
        woff       = '0;
        wsize      = '0;
        wused      = 1'b0;
        roff       = at_reg;
        unique case (state_reg)
            bth_pkg::S_IDLE:
            begin
                if (q_valid && (!ov_reg || m_tready))
                begin
                    q_pop      = 1'b1;
                    oaddr_next = '0;
                    ost_next   = q_cmd.status;
                    at_next    = '0;
                    need_next  = OW'(q_cmd.arg) + OW'(16);
                    hdr_next   = OW'(q_cmd.arg);
                    unique case (q_cmd.op)
                        bth_pkg::OP_ALLOC:  state_next = bth_pkg::S_A_RD;
                        bth_pkg::OP_FREE:
                            state_next = (OW'(q_cmd.arg) < limit_reg) ?
                                         bth_pkg::S_F_RD : bth_pkg::S_OUT;
                        bth_pkg::OP_FORMAT:
                        begin
                            if (endv < OW'(16))
                            begin
                                ost_next   = bth_pkg::ST_SMALL;
                                state_next = bth_pkg::S_OUT;
                            end
                            else
                            begin
                                limit_next = endv;
                                state_next = bth_pkg::S_FMT0;
                            end
                        end
                        bth_pkg::OP_RESULT: state_next = bth_pkg::S_OUT;
                    endcase
                end
            end
            bth_pkg::S_FMT0:
            begin
                we = 1'b1; woff = '0; wsize = limit_reg;
                state_next = bth_pkg::S_FMT1;
            end
            bth_pkg::S_FMT1:
            begin
                we = 1'b1; woff = limit_reg - OW'(8); wsize = limit_reg;
                state_next = bth_pkg::S_OUT;
            end
            bth_pkg::S_A_RD:
            begin
                roff = at_reg;
                if (at_reg < limit_reg)
                begin
                    state_next = bth_pkg::S_A_WT;
                end
                else
                begin
                    ost_next   = bth_pkg::ST_NOFIT;
                    state_next = bth_pkg::S_OUT;
                end
            end
            bth_pkg::S_A_WT:
            begin
                state_next = bth_pkg::S_A_CHK;
            end
            bth_pkg::S_A_CHK:
            begin
                size_next = tsz;
                if (!szok)
                begin
                    ost_next   = bth_pkg::ST_NOFIT;
                    state_next = bth_pkg::S_OUT;
                end
                else if (!tused && tsz >= need_reg)
                begin
                    oaddr_next = 15'(at_reg + OW'(8));
                    if (tsz - need_reg < OW'(16))
                    begin
                        need_next = tsz;
                    end
                    state_next = bth_pkg::S_A_W0;
                end
                else
                begin
                    at_next    = at_reg + tsz;
                    state_next = bth_pkg::S_A_RD;
                end
            end
            bth_pkg::S_A_W0:
            begin
                we = 1'b1; woff = at_reg; wsize = need_reg; wused = 1'b1;
                state_next = bth_pkg::S_A_W1;
            end
            bth_pkg::S_A_W1:
            begin
                we = 1'b1; woff = at_reg + need_reg - OW'(8); wsize = need_reg;
                wused = 1'b1;
                state_next = (need_reg == size_reg) ? bth_pkg::S_OUT : bth_pkg::S_A_W2;
            end
            bth_pkg::S_A_W2:
            begin
                we = 1'b1; woff = at_reg + need_reg; wsize = size_reg - need_reg;
                state_next = bth_pkg::S_A_W3;
            end
            bth_pkg::S_A_W3:
            begin
                we = 1'b1; woff = at_reg + size_reg - OW'(8);
                wsize = size_reg - need_reg;
                state_next = bth_pkg::S_OUT;
            end
            bth_pkg::S_F_RD:
            begin
                roff = hdr_reg;
                at_next = hdr_reg;
                state_next = bth_pkg::S_F_WT;
            end
            bth_pkg::S_F_WT:
            begin
                state_next = bth_pkg::S_F_CHK;
            end
            bth_pkg::S_F_CHK:
            begin
                size_next = tsz;
                if (!szok || !tused)
                begin
                    state_next = bth_pkg::S_OUT;
                end
                else
                begin
                    at_next    = hdr_reg + tsz;
                    state_next = (hdr_reg + tsz < limit_reg) ?
                                 bth_pkg::S_F_NRD : bth_pkg::S_F_PRD;
                end
            end
            bth_pkg::S_F_NRD:
            begin
                roff = at_reg;
                state_next = bth_pkg::S_F_NWT;
            end
            bth_pkg::S_F_NWT:
            begin
                state_next = bth_pkg::S_F_PRD;
            end
            bth_pkg::S_F_PRD:
            begin
                if (at_reg < limit_reg && at_reg == hdr_reg + size_reg && !tused &&
                    szok)
                begin
                    size_next = size_reg + tsz;
                end
                roff = hdr_reg - OW'(8);
                at_next = '1;
                state_next = (hdr_reg != '0) ? bth_pkg::S_F_PWT : bth_pkg::S_F_W0;
            end
            bth_pkg::S_F_PWT:
            begin
                roff       = hdr_reg - OW'(8);
                at_next    = '0;
                state_next = bth_pkg::S_F_W0;
            end
            bth_pkg::S_F_W0:
            begin
                if (at_reg == '0 && !tused && tsz >= OW'(16) && tsz[2:0] == 3'd0 &&
                    tsz <= hdr_reg)
                begin
                    hdr_next  = hdr_reg - tsz;
                    size_next = size_reg + tsz;
                    state_next = bth_pkg::S_F_W0;
                    at_next    = '1;
                end
                else
                begin
                    we = 1'b1; woff = hdr_reg; wsize = size_reg;
                    state_next = bth_pkg::S_F_W1;
                end
            end
            bth_pkg::S_F_W1:
            begin
                we = 1'b1; woff = hdr_reg + size_reg - OW'(8); wsize = size_reg;
                state_next = bth_pkg::S_OUT;
            end
            bth_pkg::S_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    state_next = bth_pkg::S_IDLE;
                end
            end
            default: state_next = bth_pkg::S_IDLE;
        endcase
    end

endmodule

>>> rtl/boundary_tag_heap_allocator_core.sv
// One item is worked at a time over the single-port tag RAM; the next one starts when the
// result register is free, so an item cannot start before the last one has finished.
// Reset clears control state and the heap limit (no heap until a format);
// heap_bytes resets to 32768. Tag RAM contents are undefined until written.
// Depends on bth_pkg, bth_front, bth_back and bth_ram.
module boundary_tag_heap_allocator_core #(
    parameter int unsigned HEAP_BYTES = bth_pkg::HEAP_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[1:0], request_bytes[17:2], block_address[32:18], zero fill
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // payload_address[14:0], status[16:15], zero fill
    output logic [23:0] m_axis_tdata
);

    logic [15:0]   heap_bytes_reg;
    logic          q_valid, q_pop;
    bth_pkg::cmd_t q_cmd;
    logic [14:0]   oaddr;
    logic [1:0]    ost;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, heap_bytes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_bytes_reg <= 16'd32768;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            heap_bytes_reg <= pwdata[15:0];
        end
    end

    bth_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata[32:0]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    bth_back #(.HEAP_BYTES(HEAP_BYTES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (q_cmd),
        .heap_bytes (heap_bytes_reg),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_addr     (oaddr),
        .m_status   (ost)
    );

    assign m_axis_tdata = {7'd0, ost, oaddr};

endmodule

>>> test/boundary_tag_heap_allocator_core_tb.sv
// Testbench for boundary_tag_heap_allocator_core: stream items are predicted by a
// boundary tag heap tracker and every result transfer is checked in order.
// Depends on bth_pkg and the core RTL.
`timescale 1ns / 1ps

module boundary_tag_heap_allocator_core_tb;
    import bth_pkg::*;

    localparam int unsigned TAG_WORDS = HEAP_BYTES_DEF / 8;
    localparam int unsigned IDLE_LIMIT = 200000;

    typedef struct {
        kind_t       kind;
        logic [15:0] req;
        logic [14:0] baddr;
        logic [14:0] exp_addr;
        status_t     exp_status;
    } xfer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    boundary_tag_heap_allocator_core u_top (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Heap tracker state.
    logic [16:0]  tags [TAG_WORDS];
    int unsigned  heap_cfg = 32768;
    int unsigned  heap_lim = 0;
    int unsigned  live_addrs [$];

    xfer_t        pending_q [$];
    xfer_t        result_q [$];
    xfer_t        cur;
    logic         s_took = 1'b0;
    int unsigned  n_taken = 0;
    int unsigned  s_idle = 20;
    int unsigned  r_idle = 75;
    int unsigned  errors = 0;
    int unsigned  quiet = 0;

    function automatic logic [16:0] tag_rd(int unsigned off);
        return (off >> 3) < TAG_WORDS ? tags[off >> 3] : 17'd0;
    endfunction

    function automatic void tag_wr(int unsigned off, int unsigned size, bit used);
        if ((off >> 3) < TAG_WORDS)
            tags[off >> 3] = {used, size[15:0]};
    endfunction

    function automatic bit block_fits(int unsigned off, int unsigned size);
        return size >= 16 && size % 8 == 0 && size <= heap_lim && off <= heap_lim - size;
    endfunction

    function automatic status_t heap_alloc(int unsigned req, output int unsigned addr);
        int unsigned need;
        int unsigned at;
        int unsigned size;
        logic [16:0] t;
        addr = 0;
        at = 0;
        if (req == 0)
            return ST_NOFIT;
        need = ((req + 7) & ~32'd7) + 16;
        while (at < heap_lim)
        begin
            t = tag_rd(at);
            size = t[15:0];
            if (!block_fits(at, size))
                return ST_NOFIT;
            if (!t[16] && size >= need)
            begin
                if (size - need >= 16)
                begin
                    tag_wr(at, need, 1);
                    tag_wr(at + need - 8, need, 1);
                    tag_wr(at + need, size - need, 0);
                    tag_wr(at + size - 8, size - need, 0);
                end
                else
                begin
                    tag_wr(at, size, 1);
                    tag_wr(at + size - 8, size, 1);
                end
                addr = at + 8;
                return ST_DONE;
            end
            at += size;
        end
        return ST_NOFIT;
    endfunction

    function automatic void heap_release(int unsigned addr);
        int unsigned hdr;
        int unsigned size;
        int unsigned ns;
        int unsigned ps;
        logic [16:0] t;
        logic [16:0] nt;
        logic [16:0] pt;
        if (addr == 0 || addr % 8 != 0 || addr - 8 >= heap_lim)
            return;
        hdr = addr - 8;
        t = tag_rd(hdr);
        size = t[15:0];
        if (!block_fits(hdr, size) || !t[16])
            return;
        if (hdr + size < heap_lim)
        begin
            nt = tag_rd(hdr + size);
            ns = nt[15:0];
            if (!nt[16] && block_fits(hdr + size, ns))
                size += ns;
        end
        if (hdr != 0)
        begin
            pt = tag_rd(hdr - 8);
            ps = pt[15:0];
            if (!pt[16] && ps >= 16 && ps % 8 == 0 && ps <= hdr)
            begin
                hdr -= ps;
                size += ps;
            end
        end
        tag_wr(hdr, size, 0);
        tag_wr(hdr + size - 8, size, 0);
    endfunction

    function automatic status_t heap_format();
        int unsigned top;
        top = heap_cfg & ~32'd7;
        if (top > HEAP_BYTES_DEF)
            top = HEAP_BYTES_DEF;
        if (top < 16)
            return ST_SMALL;
        heap_lim = top;
        tag_wr(0, top, 0);
        tag_wr(top - 8, top, 0);
        live_addrs.delete();
        return ST_DONE;
    endfunction

    task automatic add_item(kind_t kind, int unsigned req, int unsigned baddr);
        xfer_t x;
        int unsigned addr;
        x.kind = kind;
        x.req = req[15:0];
        x.baddr = baddr[14:0];
        x.exp_addr = '0;
        x.exp_status = ST_DONE;
        case (kind)
            KIND_ALLOC:
            begin
                x.exp_status = heap_alloc(req[15:0], addr);
                if (x.exp_status == ST_DONE)
                begin
                    x.exp_addr = addr[14:0];
                    live_addrs.push_back(addr);
                end
            end
            KIND_FREE:
            begin
                heap_release(baddr[14:0]);
                foreach (live_addrs[i])
                    if (live_addrs[i] == baddr)
                    begin
                        live_addrs.delete(i);
                        break;
                    end
            end
            KIND_FORMAT: x.exp_status = heap_format();
            default: ;
        endcase
        pending_q.push_back(x);
    endtask

    task automatic free_live(int unsigned idx);
        add_item(KIND_FREE, $urandom, live_addrs[idx]);
    endtask

    task automatic random_item();
        int unsigned r;
        int unsigned s;
        int unsigned a;
        r = $urandom_range(99);
        s = $urandom_range(99);
        if (r < 50 || (r < 85 && live_addrs.size() == 0) || r >= 96)
        begin
            if (s < 70)
                a = $urandom_range(64, 1);
            else if (s < 90)
                a = $urandom_range(400, 1);
            else if (s < 95)
                a = 0;
            else
                a = $urandom_range(65535);
            add_item(KIND_ALLOC, a, $urandom);
        end
        else if (r < 85)
            free_live($urandom_range(live_addrs.size() - 1));
        else if (r < 89)
            add_item(KIND_FREE, $urandom, s < 20 ? 0 : ($urandom_range(32767) | 15'd1));
        else if (r < 92)
        begin
            if (heap_lim <= 16384)
                add_item(KIND_FREE, $urandom, $urandom_range(32767, heap_lim + 8));
            else
                add_item(KIND_FREE, $urandom, $urandom_range(32767) | 15'd4);
        end
        else if (r < 94)
            add_item(KIND_NONE, $urandom, $urandom);
        else
            add_item(KIND_FORMAT, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_heap_bytes(int unsigned value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        heap_cfg = value & 32'hFFFF;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_took))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= s_idle)
            begin
                cur = pending_q.pop_front();
                s_axis_tdata <= {7'd0, cur.baddr, cur.req, cur.kind};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= rst_n && $urandom_range(99) >= r_idle;
    end

    always @(posedge clk)
    begin
        xfer_t x;
        s_took <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            result_q.push_back(cur);
            n_taken++;
            if (n_taken == 550)
            begin
                s_idle = 75;
                r_idle = 20;
            end
            else if (n_taken == 1100)
            begin
                s_idle = 0;
                r_idle = 0;
            end
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                x = result_q.pop_front();
                if (m_axis_tdata[14:0] != x.exp_addr)
                begin
                    $display("%0t: payload_address expected %0d actual %0d",
                             $time, x.exp_addr, m_axis_tdata[14:0]);
                    errors++;
                end
                if (m_axis_tdata[16:15] != x.exp_status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, x.exp_status, m_axis_tdata[16:15]);
                    errors++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned cfg_vals [7];
        int unsigned cfg_items [7];
        foreach (tags[i])
            tags[i] = '0;
        cfg_vals = '{8, 16, 65535, 1027, 4096, 512, 32768};
        cfg_items = '{15, 30, 280, 400, 480, 300, 100};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_item(KIND_ALLOC, 5, 0);
        add_item(KIND_FREE, 0, 8);
        add_item(KIND_NONE, 16'hFFFF, 15'h7FFF);
        add_item(KIND_FORMAT, 0, 0);
        add_item(KIND_ALLOC, 0, 0);
        add_item(KIND_ALLOC, 1, 0);
        add_item(KIND_ALLOC, 8, 0);
        add_item(KIND_ALLOC, 9, 0);
        add_item(KIND_ALLOC, 32768, 0);
        add_item(KIND_ALLOC, 65535, 0);
        add_item(KIND_ALLOC, 32640, 0);
        add_item(KIND_ALLOC, 24, 0);
        add_item(KIND_FREE, 0, 0);
        add_item(KIND_FREE, 0, 13);
        free_live(1);
        free_live(0);
        free_live(live_addrs.size() - 1);
        add_item(KIND_ALLOC, 40, 0);
        while (live_addrs.size() != 0)
            free_live(0);
        add_item(KIND_ALLOC, 32736, 0);

        foreach (cfg_vals[p])
        begin
            wait_idle();
            write_heap_bytes(cfg_vals[p]);
            add_item(KIND_FORMAT, $urandom, $urandom);
            repeat (cfg_items[p])
                random_item();
        end
        wait_idle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
